>>> rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and the control store of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int SKF_SAMPLE_WIDTH   = 16;
  localparam int SKF_VARIANCE_WIDTH = 24;
  localparam int GAIN_WIDTH         = 16;
  localparam int ROUND_HALF         = 1 << (GAIN_WIDTH - 1);
  localparam logic [GAIN_WIDTH:0] GAIN_ONE = (GAIN_WIDTH + 1)'(1) << GAIN_WIDTH;

  // configuration registers
  localparam int CFG_IDX_WIDTH       = 1;
  localparam int PROCESS_NOISE_RESET = 1442;
  localparam int MEASURE_NOISE_RESET = 40436;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PROCESS_NOISE = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MEASURE_NOISE = 1'b1;

  // microprogram addressing
  localparam int PC_WIDTH = 4;
  localparam logic [PC_WIDTH-1:0] A_IDLE   = 4'd0;
  localparam logic [PC_WIDTH-1:0] A_PRED   = 4'd1;
  localparam logic [PC_WIDTH-1:0] A_DIV    = 4'd2;
  localparam logic [PC_WIDTH-1:0] A_GAIN   = 4'd3;
  localparam logic [PC_WIDTH-1:0] A_MUL_E  = 4'd4;
  localparam logic [PC_WIDTH-1:0] A_ACC_E  = 4'd5;
  localparam logic [PC_WIDTH-1:0] A_MUL_VL = 4'd6;
  localparam logic [PC_WIDTH-1:0] A_MUL_VH = 4'd7;
  localparam logic [PC_WIDTH-1:0] A_ACC_V  = 4'd8;
  localparam logic [PC_WIDTH-1:0] A_LOAD   = 4'd14;
  localparam logic [PC_WIDTH-1:0] A_EMIT   = 4'd15;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_PRED,
    OP_DIV,
    OP_GAIN,
    OP_MUL_E,
    OP_ACC_E,
    OP_MUL_VL,
    OP_MUL_VH,
    OP_ACC_V,
    OP_LOAD,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_IN,
    COND_LOAD,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e                 op;
    cond_e               cond;
    logic [PC_WIDTH-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_e op;
  } ctl_t;

  typedef struct packed {
    logic in_take;
    logic load;
    logic div_more;
    logic out_busy;
  } stat_t;

  // control store: a true condition jumps to target, otherwise step on
  function automatic ucode_t skf_rom(input logic [PC_WIDTH-1:0] addr);
    ucode_t w;
    case (addr)
      A_IDLE:   w = '{op: OP_IDLE,   cond: COND_NO_IN,    target: A_IDLE};
      A_PRED:   w = '{op: OP_PRED,   cond: COND_LOAD,     target: A_LOAD};
      A_DIV:    w = '{op: OP_DIV,    cond: COND_DIV_MORE, target: A_DIV};
      A_GAIN:   w = '{op: OP_GAIN,   cond: COND_NONE,     target: A_IDLE};
      A_MUL_E:  w = '{op: OP_MUL_E,  cond: COND_NONE,     target: A_IDLE};
      A_ACC_E:  w = '{op: OP_ACC_E,  cond: COND_NONE,     target: A_IDLE};
      A_MUL_VL: w = '{op: OP_MUL_VL, cond: COND_NONE,     target: A_IDLE};
      A_MUL_VH: w = '{op: OP_MUL_VH, cond: COND_NONE,     target: A_IDLE};
      A_ACC_V:  w = '{op: OP_ACC_V,  cond: COND_ALWAYS,   target: A_EMIT};
      A_LOAD:   w = '{op: OP_LOAD,   cond: COND_NONE,     target: A_IDLE};
      // last address: stepping on wraps to idle
      A_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_BUSY, target: A_EMIT};
      default:  w = '{op: OP_NOP,    cond: COND_ALWAYS,   target: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/scalar_kalman_filter_top.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// One-dimensional fixed-point Kalman filter for a constant level.
// ----------------------------------------------------------------------------
// usage:
//   input beat (in_valid_i/in_ready_o) carries a Q4.12 measurement and a
//   restart flag; each input beat yields one output beat (out_valid_o /
//   out_ready_i) with the new estimate, the gain used and the Q8.16 variance.
//   q and r are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// sequence:
//   an update runs one predict step, a one-bit-per-cycle restoring divider
//   for the gain, then six steps that set the gain and use the single shared
//   multiplier, and one emit step; the next beat is taken only after emit.
//   a load (first beat after reset, or restart set) goes from the predict
//   step to a load step and then to the emit step.
// reset:
//   estimate and variance clear, the next beat loads, q and r return to
//   their defaults; no beat is pending on either side.
// stall:
//   a finished result sits in the output register while the next beat is
//   taken and computed; its emit step waits until that register is free.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top
  import skf_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SKF_SAMPLE_WIDTH,
  parameter int VARIANCE_WIDTH = SKF_VARIANCE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_idx_i,
  input  logic [VARIANCE_WIDTH-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] measurement_i,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] estimate_o,
  output logic [GAIN_WIDTH-1:0]          gain_o,
  output logic [VARIANCE_WIDTH-1:0]      variance_o
);

  ctl_t  ctl;
  stat_t stat;

  skf_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  skf_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .VARIANCE_WIDTH (VARIANCE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .measurement_i (measurement_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .estimate_o    (estimate_o),
    .gain_o        (gain_o),
    .variance_o    (variance_o)
  );

endmodule

>>> rtl/skf_seq.sv
// ----------------------------------------------------------------------------
// skf_seq
// Microprogram sequencer: step counter, control store fetch and jump logic.
// ----------------------------------------------------------------------------
module skf_seq
  import skf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  logic [PC_WIDTH-1:0] pc_q, pc_d;
  ucode_t              uw;
  logic                take_jump;

  assign uw        = skf_rom(pc_q);
  assign ctl_o.op  = uw.op;

  always_comb begin
    case (uw.cond)
      COND_NONE:     take_jump = 1'b0;
      COND_ALWAYS:   take_jump = 1'b1;
      COND_NO_IN:    take_jump = !stat_i.in_take;
      COND_LOAD:     take_jump = stat_i.load;
      COND_DIV_MORE: take_jump = stat_i.div_more;
      COND_OUT_BUSY: take_jump = stat_i.out_busy;
      default:       take_jump = 1'b1;
    endcase
    pc_d = take_jump ? uw.target : pc_q + PC_WIDTH'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= A_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> rtl/skf_datapath.sv
// ----------------------------------------------------------------------------
// skf_datapath
// Filter state, restoring divider, shared multiplier, config and output regs.
// ----------------------------------------------------------------------------
module skf_datapath
  import skf_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SKF_SAMPLE_WIDTH,
  parameter int VARIANCE_WIDTH = SKF_VARIANCE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ctl_t                             ctl_i,
  output stat_t                            stat_o,
  input  logic                             cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]         cfg_idx_i,
  input  logic [VARIANCE_WIDTH-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]   measurement_i,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]   estimate_o,
  output logic [GAIN_WIDTH-1:0]            gain_o,
  output logic [VARIANCE_WIDTH-1:0]        variance_o
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int VW   = VARIANCE_WIDTH;
  localparam int HALF = (VW + 1) / 2;
  localparam int AW   = GAIN_WIDTH + 2;
  localparam int MB   = (SW + 1 > HALF + 1) ? SW + 1 : HALF + 1;
  localparam int PW   = AW + MB;
  localparam int TW   = VW + GAIN_WIDTH + 2;
  localparam int CW   = $clog2(GAIN_WIDTH);

  // control state
  logic          primed_q, primed_d;
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // payload
  logic [VW-1:0]          q_q, q_d, r_q, r_d;
  logic signed [SW-1:0]   z_q, z_d, x_q, x_d, est_q, est_d;
  logic                   restart_q, restart_d, r_zero_q, r_zero_d;
  logic [VW-1:0]          p_q, p_d, pp_q, pp_d, var_q, var_d;
  logic [VW:0]            den_q, den_d, rem_q, rem_d;
  logic [GAIN_WIDTH-1:0]  quo_q, quo_d, gain_q, gain_d, gout_q, gout_d;
  logic signed [SW:0]     diff_q, diff_d;
  logic signed [PW-1:0]   prod_q, prod_d;
  logic [PW-1:0]          lo_q, lo_d;

  // datapath nets
  logic                   in_take, out_busy;
  logic [VW:0]            pq_sum;
  logic [VW-1:0]          pp_sat;
  logic [VW+1:0]          rem_sh, rem_sub;
  logic                   qbit;
  logic signed [AW-1:0]   mul_a;
  logic signed [MB-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p, rnd_e, corr_e;
  logic [TW-1:0]          total_v;

  assign in_ready_o = (ctl_i.op == OP_IDLE);
  assign in_take    = in_valid_i && in_ready_o;
  assign out_busy   = out_valid_q && !out_ready_i;

  assign stat_o.in_take  = in_take;
  assign stat_o.load     = !primed_q || restart_q;
  assign stat_o.div_more = (cnt_q != {CW{1'b1}});
  assign stat_o.out_busy = out_busy;

  assign out_valid_o = out_valid_q;
  assign estimate_o  = est_q;
  assign gain_o      = gout_q;
  assign variance_o  = var_q;

  // predicted variance, saturating
  assign pq_sum = {1'b0, p_q} + {1'b0, q_q};
  assign pp_sat = pq_sum[VW] ? {VW{1'b1}} : pq_sum[VW-1:0];

  // one restoring divide step
  assign rem_sh  = {rem_q, 1'b0};
  assign qbit    = (rem_sh >= {1'b0, den_q});
  assign rem_sub = qbit ? rem_sh - {1'b0, den_q} : rem_sh;

  // shared multiplier: gain * diff, or (1 - gain) * one half of pp
  always_comb begin
    if (ctl_i.op == OP_MUL_E) begin
      mul_a = AW'({2'b00, gain_q});
    end else begin
      mul_a = AW'({1'b0, GAIN_ONE - {1'b0, gain_q}});
    end
    case (ctl_i.op)
      OP_MUL_E:  mul_b = MB'(diff_q);
      OP_MUL_VL: mul_b = MB'(pp_q[HALF-1:0]);
      default:   mul_b = MB'(pp_q[VW-1:HALF]);
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign rnd_e  = prod_q + PW'(ROUND_HALF);
  assign corr_e = rnd_e >>> GAIN_WIDTH;
  assign total_v = TW'(lo_q) + (TW'($unsigned(prod_q)) << HALF) + TW'(ROUND_HALF);

  always_comb begin
    primed_d    = primed_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    q_d         = q_q;
    r_d         = r_q;
    z_d         = z_q;
    restart_d   = restart_q;
    x_d         = x_q;
    p_d         = p_q;
    pp_d        = pp_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    r_zero_d    = r_zero_q;
    gain_d      = gain_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    lo_d        = lo_q;
    est_d       = est_q;
    gout_d      = gout_q;
    var_d       = var_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROCESS_NOISE: q_d = cfg_data_i;
        REG_MEASURE_NOISE: r_d = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (ctl_i.op)
      OP_IDLE: begin
        if (in_take) begin
          z_d       = measurement_i;
          restart_d = restart_i;
        end
      end
      OP_PRED: begin
        pp_d     = pp_sat;
        den_d    = {1'b0, pp_sat} + {1'b0, r_q};
        rem_d    = {1'b0, pp_sat};
        cnt_d    = '0;
        r_zero_d = (r_q == '0);
      end
      OP_DIV: begin
        rem_d = rem_sub[VW:0];
        quo_d = {quo_q[GAIN_WIDTH-2:0], qbit};
        cnt_d = cnt_q + CW'(1);
      end
      OP_GAIN: begin
        // no measurement noise: unit gain saturates, or zero over zero
        if (r_zero_q) begin
          gain_d = (pp_q != '0) ? {GAIN_WIDTH{1'b1}} : '0;
        end else begin
          gain_d = quo_q;
        end
        diff_d = {z_q[SW-1], z_q} - {x_q[SW-1], x_q};
      end
      OP_MUL_E:  prod_d = mul_p;
      OP_ACC_E:  x_d = x_q + corr_e[SW-1:0];
      OP_MUL_VL: prod_d = mul_p;
      OP_MUL_VH: begin
        lo_d   = prod_q;
        prod_d = mul_p;
      end
      OP_ACC_V:  p_d = total_v[VW+GAIN_WIDTH-1:GAIN_WIDTH];
      OP_LOAD: begin
        x_d      = z_q;
        p_d      = '0;
        gain_d   = '0;
        primed_d = 1'b1;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          est_d       = x_q;
          gout_d      = gain_q;
          var_d       = p_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      q_q         <= VW'(PROCESS_NOISE_RESET);
      r_q         <= VW'(MEASURE_NOISE_RESET);
      x_q         <= '0;
      p_q         <= '0;
    end else begin
      primed_q    <= primed_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      q_q         <= q_d;
      r_q         <= r_d;
      x_q         <= x_d;
      p_q         <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q       <= z_d;
    restart_q <= restart_d;
    pp_q      <= pp_d;
    den_q     <= den_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    r_zero_q  <= r_zero_d;
    gain_q    <= gain_d;
    diff_q    <= diff_d;
    prod_q    <= prod_d;
    lo_q      <= lo_d;
    est_q     <= est_d;
    gout_q    <= gout_d;
    var_q     <= var_d;
  end

  // divider remainder must stay below the divisor when r is nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_DIV && !r_zero_q) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  // corrected variance never exceeds the predicted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_ACC_V) |=> (p_q <= pp_q))
    else $error("variance grew in update");

  // updated estimate lies between old estimate and measurement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_ACC_E) |=>
      ((x_q >= $past(x_q)) && (x_q <= $past(z_q))) ||
      ((x_q <= $past(x_q)) && (x_q >= $past(z_q))))
    else $error("estimate left the interval");

endmodule
